// ----- rtl/core/etl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event threshold limiter package
// Shared types and constants: control word layout, sequencer steps, branch
// conditions, table entry layout and configuration register indexes.
// ----------------------------------------------------------------------------
package etl_pkg;

    localparam int unsigned KEY_W     = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned PERIOD_W  = 24;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned J_W       = 5;

    localparam logic [PERIOD_W-1:0] MAX_LIMIT_DEFAULT = 24'd86400;
    localparam logic [COUNT_W-1:0]  EVENT_COUNT_DEFAULT = 16'd1;

    // Key reduction runs two steps: the quotient first, then the remainder.
    localparam logic [J_W-1:0] J_KEY_START = 5'd1;
    localparam logic [J_W-1:0] J_DIV_START = 5'(TIME_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_KRED,
        ST_EV_RD,
        ST_EV_LOAD,
        ST_DIV,
        ST_EV_UPD,
        ST_TICK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } step_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_FIRE,
        COND_OP_TICK,
        COND_J_ZERO,
        COND_CTR_LAST,
        COND_THR_ON,
        COND_SLOT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ZERO,
        WR_EXPIRE,
        WR_EVENT
    } wr_mode_t;

    typedef enum logic {
        ADDR_CTR,
        ADDR_KEY
    } addr_sel_t;

    typedef enum logic [1:0] {
        J_HOLD,
        J_KEY,
        J_DIV,
        J_DEC
    } j_op_t;

    typedef enum logic [1:0] {
        CTR_HOLD,
        CTR_ZERO,
        CTR_INC
    } ctr_op_t;

    // Datapath controls carried by one microcode word.
    typedef struct packed {
        logic      in_ready;
        logic      mem_rd;
        wr_mode_t  wr_mode;
        addr_sel_t addr_sel;
        j_op_t     j_op;
        ctr_op_t   ctr_op;
        logic      kred;
        logic      ld_entry;
        logic      div_step;
        logic      sec_inc;
        logic      emit;
    } ctl_t;

    typedef struct packed {
        cond_t cond;
        step_t t_true;
        step_t t_false;
        ctl_t  ctl;
    } ucode_t;

    // Status returned by the datapath for branch decisions.
    typedef struct packed {
        logic in_fire;
        logic op_tick;
        logic j_zero;
        logic ctr_last;
        logic thr_on;
        logic slot_free;
    } flags_t;

    typedef struct packed {
        logic [TIME_W-1:0] count;
        logic [TIME_W-1:0] deadline;
        logic              timed;
    } entry_t;

endpackage
`default_nettype wire

// ----- rtl/core/etl_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event threshold limiter key table
// One entry per key: event count, deadline and armed flag. One write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module etl_table
    import etl_pkg::*;
#(
    parameter int unsigned KEYS = 1024,
    localparam int unsigned AW = $clog2(KEYS)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t entry_mem [KEYS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/core/etl_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event threshold limiter sequencer
// Step counter and control store. Each step issues one control word and
// branches to one of two successors on a selected datapath condition.
// ----------------------------------------------------------------------------
module etl_sequencer
    import etl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctl_t        ctl
);

    step_t  step_reg;
    step_t  step_next;
    ucode_t word;
    logic   cond_true;

    // Control store.
    always_comb
    begin
        word = '0;
        word.cond = COND_ALWAYS;
        word.t_true = ST_IDLE;
        word.t_false = ST_IDLE;
        word.ctl.wr_mode = WR_NONE;
        word.ctl.addr_sel = ADDR_CTR;
        word.ctl.j_op = J_HOLD;
        word.ctl.ctr_op = CTR_HOLD;
        unique case (step_reg)
            ST_CLEAR:
            begin
                word.ctl.wr_mode = WR_ZERO;
                word.ctl.ctr_op = CTR_INC;
                word.cond = COND_CTR_LAST;
                word.t_true = ST_IDLE;
                word.t_false = ST_CLEAR;
            end
            ST_IDLE:
            begin
                word.ctl.in_ready = 1'b1;
                word.cond = COND_IN_FIRE;
                word.t_true = ST_DECODE;
                word.t_false = ST_IDLE;
            end
            ST_DECODE:
            begin
                word.ctl.j_op = J_KEY;
                word.cond = COND_OP_TICK;
                word.t_true = ST_TICK;
                word.t_false = ST_KRED;
            end
            ST_KRED:
            begin
                word.ctl.kred = 1'b1;
                word.ctl.j_op = J_DEC;
                word.cond = COND_J_ZERO;
                word.t_true = ST_EV_RD;
                word.t_false = ST_KRED;
            end
            ST_EV_RD:
            begin
                word.ctl.mem_rd = 1'b1;
                word.ctl.addr_sel = ADDR_KEY;
                word.t_true = ST_EV_LOAD;
                word.t_false = ST_EV_LOAD;
            end
            ST_EV_LOAD:
            begin
                word.ctl.ld_entry = 1'b1;
                word.ctl.j_op = J_DIV;
                word.cond = COND_THR_ON;
                word.t_true = ST_DIV;
                word.t_false = ST_EV_UPD;
            end
            ST_DIV:
            begin
                word.ctl.div_step = 1'b1;
                word.ctl.j_op = J_DEC;
                word.cond = COND_J_ZERO;
                word.t_true = ST_EV_UPD;
                word.t_false = ST_DIV;
            end
            ST_EV_UPD:
            begin
                word.ctl.wr_mode = WR_EVENT;
                word.ctl.addr_sel = ADDR_KEY;
                word.t_true = ST_EMIT;
                word.t_false = ST_EMIT;
            end
            ST_TICK:
            begin
                word.ctl.sec_inc = 1'b1;
                word.ctl.ctr_op = CTR_ZERO;
                word.t_true = ST_SCAN_RD;
                word.t_false = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                word.ctl.mem_rd = 1'b1;
                word.t_true = ST_SCAN_CHK;
                word.t_false = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                word.ctl.wr_mode = WR_EXPIRE;
                word.ctl.ctr_op = CTR_INC;
                word.cond = COND_CTR_LAST;
                word.t_true = ST_EMIT;
                word.t_false = ST_SCAN_RD;
            end
            ST_EMIT:
            begin
                word.ctl.emit = 1'b1;
                word.cond = COND_SLOT_FREE;
                word.t_true = ST_IDLE;
                word.t_false = ST_EMIT;
            end
            default:
            begin
                word.t_true = ST_IDLE;
                word.t_false = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_IN_FIRE:   cond_true = flags.in_fire;
            COND_OP_TICK:   cond_true = flags.op_tick;
            COND_J_ZERO:    cond_true = flags.j_zero;
            COND_CTR_LAST:  cond_true = flags.ctr_last;
            COND_THR_ON:    cond_true = flags.thr_on;
            COND_SLOT_FREE: cond_true = flags.slot_free;
            default:        cond_true = 1'b1;
        endcase
        step_next = cond_true ? word.t_true : word.t_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl = word.ctl;

endmodule
`default_nettype wire

// ----- rtl/core/etl_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event threshold limiter datapath
// Configuration registers, seconds counter, key reduction and count modulo
// units, entry update logic and the output register.
// ----------------------------------------------------------------------------
module etl_datapath
    import etl_pkg::*;
#(
    parameter int unsigned KEYS = 1024,
    localparam int unsigned AW = $clog2(KEYS)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctl_t                 ctl,
    output flags_t                    flags,
    input  wire logic                 in_valid,
    input  wire logic                 operation,
    input  wire logic [KEY_W-1:0]     key_index,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_data,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      forward,
    output logic                      is_event,
    output logic                      tbl_wr_en,
    output logic                      tbl_rd_en,
    output logic [AW-1:0]             tbl_addr,
    output entry_t                    tbl_wdata,
    input  wire entry_t               tbl_rdata
);

    // Reciprocal of KEYS, exact for every key_index value.
    localparam int unsigned RECIP_SHIFT = KEY_W + AW;
    localparam int unsigned KEY_RECIP   = ((32'd1 << RECIP_SHIFT) + KEYS - 1) / KEYS;

    logic [PERIOD_W-1:0] thr_reg;
    logic [PERIOD_W-1:0] lim_reg;
    logic [PERIOD_W-1:0] max_reg;
    logic [COUNT_W-1:0]  count_cfg_reg;

    logic [TIME_W-1:0]   seconds_reg;
    logic                op_reg;
    logic [KEY_W-1:0]    rem_reg;
    logic [KEY_W-1:0]    quo_reg;
    logic [J_W-1:0]      j_reg;
    logic [AW-1:0]       ctr_reg;
    logic [TIME_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]   dl_reg;
    logic                timed_reg;
    logic [COUNT_W-1:0]  divr_reg;
    logic                fwd_reg;
    logic                out_valid_reg;
    logic                forward_reg;
    logic                is_event_reg;

    logic                in_fire;
    logic                slot_free;
    logic [COUNT_W-1:0]  n_eff;
    logic [TIME_W-1:0]   n_ext;
    logic [TIME_W-1:0]   rem_ext;
    logic [TIME_W-1:0]   kred_prod;
    logic [TIME_W-1:0]   kred_back;
    logic [KEY_W-1:0]    quo_calc;
    logic [KEY_W-1:0]    rem_calc;
    logic [COUNT_W:0]    div_shift;
    logic [COUNT_W:0]    div_n;
    logic [TIME_W-1:0]   rd_count_inc;

    logic                thr_on;
    logic                lim_on;
    logic                mod_zero;
    logic                c_is1;
    logic                c_isn;
    logic                c_gtn;
    logic                lim_stage;
    logic                arm;
    logic                fwd_calc;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] period_eff;
    logic [TIME_W-1:0]   new_dl;

    assign in_fire   = in_valid && ctl.in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign thr_on    = thr_reg != '0;
    assign lim_on    = lim_reg != '0;
    assign n_eff     = (count_cfg_reg == '0) ? COUNT_W'(1) : count_cfg_reg;
    assign n_ext     = TIME_W'(n_eff);

    assign flags.in_fire   = in_fire;
    assign flags.op_tick   = op_reg;
    assign flags.j_zero    = j_reg == '0;
    assign flags.ctr_last  = ctr_reg == AW'(KEYS - 1);
    assign flags.thr_on    = thr_on;
    assign flags.slot_free = slot_free;

    // Key reduction by reciprocal multiplication: the quotient in the first
    // step, the remainder in the second.
    assign rem_ext   = TIME_W'(rem_reg);
    assign kred_prod = rem_ext * TIME_W'(KEY_RECIP);
    assign quo_calc  = KEY_W'(kred_prod >> RECIP_SHIFT);
    assign kred_back = TIME_W'(quo_reg) * TIME_W'(KEYS);
    assign rem_calc  = KEY_W'(rem_ext - kred_back);

    // Count modulo the count setting, one dividend bit per step.
    assign div_shift = {divr_reg, cnt_reg[j_reg]};
    assign div_n     = {1'b0, n_eff};

    assign rd_count_inc = (tbl_rdata.count == '1) ? tbl_rdata.count : tbl_rdata.count + 1'b1;

    // Entry update decision. When several deadlines are armed for one event,
    // the last one in the rule order wins, hence the priority below.
    always_comb
    begin
        mod_zero  = divr_reg == '0;
        c_is1     = cnt_reg == TIME_W'(1);
        c_isn     = cnt_reg == n_ext;
        c_gtn     = cnt_reg > n_ext;
        lim_stage = lim_on && (!thr_on || mod_zero);
        arm       = 1'b1;
        period    = '0;
        priority if (lim_stage && c_isn)
        begin
            period = lim_reg;
        end
        else if (lim_stage && c_is1)
        begin
            period = max_reg;
        end
        else if (thr_on && c_is1)
        begin
            period = thr_reg;
        end
        else
        begin
            arm = 1'b0;
        end
        period_eff = (period == '0) ? PERIOD_W'(1) : period;
        new_dl     = seconds_reg + TIME_W'(period_eff);
        priority if (thr_on)
        begin
            fwd_calc = mod_zero && (!lim_on || !c_gtn);
        end
        else if (lim_on)
        begin
            fwd_calc = !c_gtn;
        end
        else
        begin
            fwd_calc = 1'b1;
        end
    end

    always_comb
    begin
        tbl_rd_en = ctl.mem_rd;
        tbl_addr  = (ctl.addr_sel == ADDR_KEY) ? AW'(rem_reg) : ctr_reg;
        tbl_wr_en = 1'b0;
        tbl_wdata = '0;
        unique case (ctl.wr_mode)
            WR_NONE:
            begin
                tbl_wr_en = 1'b0;
            end
            WR_ZERO:
            begin
                tbl_wr_en = 1'b1;
            end
            WR_EXPIRE:
            begin
                tbl_wr_en = tbl_rdata.timed && (tbl_rdata.deadline == seconds_reg);
            end
            WR_EVENT:
            begin
                tbl_wr_en          = 1'b1;
                tbl_wdata.count    = cnt_reg;
                tbl_wdata.deadline = arm ? new_dl : dl_reg;
                tbl_wdata.timed    = arm || timed_reg;
            end
        endcase
    end

    // Configuration, counters and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            lim_reg       <= '0;
            max_reg       <= MAX_LIMIT_DEFAULT;
            count_cfg_reg <= EVENT_COUNT_DEFAULT;
            seconds_reg   <= '0;
            j_reg         <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD:   thr_reg <= cfg_data;
                    CFG_LIMIT:       lim_reg <= cfg_data;
                    CFG_MAX_LIMIT:   max_reg <= cfg_data;
                    CFG_EVENT_COUNT: count_cfg_reg <= cfg_data[COUNT_W-1:0];
                endcase
            end
            if (ctl.sec_inc)
            begin
                seconds_reg <= seconds_reg + 1'b1;
            end
            unique case (ctl.j_op)
                J_HOLD: j_reg <= j_reg;
                J_KEY:  j_reg <= J_KEY_START;
                J_DIV:  j_reg <= J_DIV_START;
                J_DEC:  j_reg <= j_reg - 1'b1;
            endcase
            unique case (ctl.ctr_op)
                CTR_ZERO: ctr_reg <= '0;
                CTR_INC:  ctr_reg <= ctr_reg + 1'b1;
                default:  ctr_reg <= ctr_reg;
            endcase
            if (ctl.emit && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= operation;
            rem_reg <= key_index;
        end
        if (ctl.kred && (j_reg != '0))
        begin
            quo_reg <= quo_calc;
        end
        if (ctl.kred && (j_reg == '0))
        begin
            rem_reg <= rem_calc;
        end
        if (ctl.ld_entry)
        begin
            cnt_reg   <= rd_count_inc;
            dl_reg    <= tbl_rdata.deadline;
            timed_reg <= tbl_rdata.timed;
            divr_reg  <= '0;
        end
        if (ctl.div_step)
        begin
            divr_reg <= (div_shift >= div_n) ? COUNT_W'(div_shift - div_n)
                                             : div_shift[COUNT_W-1:0];
        end
        if (ctl.wr_mode == WR_EVENT)
        begin
            fwd_reg <= fwd_calc;
        end
        if (ctl.sec_inc)
        begin
            fwd_reg <= 1'b0;
        end
        if (ctl.emit && slot_free)
        begin
            forward_reg  <= fwd_reg;
            is_event_reg <= !op_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign forward   = forward_reg;
    assign is_event  = is_event_reg;

endmodule
`default_nettype wire

// ----- rtl/core/event_threshold_limiter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event threshold limiter
// Per-key alert suppression by event threshold and rate limit, run by a
// microcoded sequencer over a key table.
// ----------------------------------------------------------------------------
// Each input word is either an event for a key or a one-second tick, and each
// gives exactly one result word. The block handles one word at a time. An
// event's result is raised after the two key reduction steps, the table read
// and the table write; when a threshold window is set, the count modulo the
// count setting runs in between, one bit a cycle over all 32 count bits. A
// tick's result is raised once every table entry has been read and, if its
// deadline is reached, cleared. The next input word can be taken in the cycle
// in which a result is raised. After reset the table is cleared, entry by
// entry, before the first input word is accepted; configuration writes are
// taken at any time. A waiting result does not stop the next input word from
// being accepted, but that word's own result is held back, and further input
// with it, until the earlier one is taken.
module event_threshold_limiter
    import etl_pkg::*;
#(
    parameter int unsigned KEYS = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic [KEY_W-1:0]     key_index,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      forward,
    output logic                      is_event,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_data
);

    localparam int unsigned AW = $clog2(KEYS);

    ctl_t          ctl;
    flags_t        flags;
    logic          tbl_wr_en;
    logic          tbl_rd_en;
    logic [AW-1:0] tbl_addr;
    entry_t        tbl_wdata;
    entry_t        tbl_rdata;

    etl_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    etl_datapath #(
        .KEYS (KEYS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .flags     (flags),
        .in_valid  (in_valid),
        .operation (operation),
        .key_index (key_index),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .forward   (forward),
        .is_event  (is_event),
        .tbl_wr_en (tbl_wr_en),
        .tbl_rd_en (tbl_rd_en),
        .tbl_addr  (tbl_addr),
        .tbl_wdata (tbl_wdata),
        .tbl_rdata (tbl_rdata)
    );

    etl_table #(
        .KEYS (KEYS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_addr),
        .wr_data (tbl_wdata),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_addr),
        .rd_data (tbl_rdata)
    );

    assign in_ready  = ctl.in_ready;
    assign cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    // Once a word is accepted the sequencer leaves the idle step at once.
    a_busy_after_accept : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input still ready after a word was accepted");

    // A result appears only after the emit step has run.
    a_result_from_emit : assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.emit)
    ) else $error("result raised without an emit step");

    // Tick results never carry a forward flag.
    a_tick_not_forwarded : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !is_event) |-> !forward
    ) else $error("tick result marked as forwarded");
`endif

endmodule
`default_nettype wire
